// ===== hdl/bitmap_extent_allocator_top_macros.svh =====
// Assertion macros used by the checker file of the allocator.
`ifndef BITMAP_EXTENT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_EXTENT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BEA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define BEA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== hdl/bea_pkg.sv =====
// ----------------------------------------------------------------------------
// bea_pkg
// Shared constants, codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package bea_pkg;

  localparam int BLOCKS      = 8192;
  localparam int MAX_EXTENTS = 16;
  localparam int FILES       = 16;

  localparam int BLK_W   = $clog2(BLOCKS);        // block address width
  localparam int SIZE_W  = BLK_W + 1;             // holds BLOCKS itself
  localparam int FILE_W  = $clog2(FILES);
  localparam int EXT_W   = $clog2(MAX_EXTENTS);
  localparam int CNT_W   = EXT_W + 1;             // holds MAX_EXTENTS itself
  localparam int SLOT_W  = FILE_W + EXT_W;
  localparam int SLOTS   = FILES * MAX_EXTENTS;

  localparam logic [SIZE_W-1:0] BLOCKS_C = SIZE_W'(BLOCKS);
  localparam logic [CNT_W-1:0]  MAX_EXT_C = CNT_W'(MAX_EXTENTS);

  // Request kinds.
  localparam logic MODE_GROW = 1'b0;
  localparam logic MODE_MAP  = 1'b1;

  // Result codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BEYOND  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // capture the request and clear the walk
    logic read;    // read the extent at the walk index
    logic accum;   // fold the read extent into the walk
    logic finish;  // decide, update the tables and load the result
  } bea_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;    // extents remain to be walked
  } bea_stat_t;

endpackage

// ===== hdl/bitmap_extent_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_extent_allocator_top: block allocator with per-file extent lists.
// A request is captured, each extent of the file is read and then accumulated,
// and the result is loaded once the output is free; no new request is taken meanwhile.
// Reset clears extent counts and the fill mark at once; no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_extent_allocator_top import bea_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [FILE_W-1:0] file_id,
  input  logic [SIZE_W-1:0] target_blocks,
  input  logic [BLK_W-1:0]  block_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [BLK_W-1:0]  block_address
);

  bea_cmd_t  cmd;
  bea_stat_t stat;

  // Sequencer.
  bea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Tables and arithmetic.
  bea_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .mode          (mode),
    .file_id       (file_id),
    .target_blocks (target_blocks),
    .block_index   (block_index),
    .cmd           (cmd),
    .stat          (stat),
    .status        (status),
    .block_address (block_address)
  );

endmodule

// ===== hdl/bea_ctrl.sv =====
// ----------------------------------------------------------------------------
// bea_ctrl
// Request sequencer: walks a file's extents, then completes the request.
// ----------------------------------------------------------------------------
module bea_ctrl import bea_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output bea_cmd_t  cmd,
  input  bea_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_ACC  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.more) begin
          cmd.read   = 1'b1;
          state_next = S_ACC;
        end else begin
          state_next = S_FIN;
        end
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        state_next = S_WALK;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/bea_dp.sv =====
// ----------------------------------------------------------------------------
// bea_dp
// Extent tables, allocation mark, walk accumulator and result register.
// ----------------------------------------------------------------------------
module bea_dp import bea_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              mode,
  input  logic [FILE_W-1:0] file_id,
  input  logic [SIZE_W-1:0] target_blocks,
  input  logic [BLK_W-1:0]  block_index,
  input  bea_cmd_t          cmd,
  output bea_stat_t         stat,
  output logic [1:0]        status,
  output logic [BLK_W-1:0]  block_address
);

  // Blocks are always taken from the lowest free one and are never released,
  // so the used blocks form a prefix: a fill mark suffices.
  logic [SIZE_W-1:0] used;

  logic [CNT_W-1:0]  ext_count [FILES];
  logic [BLK_W-1:0]  ext_start [SLOTS];
  logic [SIZE_W-1:0] ext_len   [SLOTS];

  logic              req_mode;
  logic [FILE_W-1:0] req_file;
  logic [SIZE_W-1:0] req_need;
  logic [BLK_W-1:0]  req_idx;

  logic [CNT_W-1:0]  k;
  logic [SIZE_W-1:0] pos;
  logic              hit;
  logic [BLK_W-1:0]  hit_addr;
  logic [BLK_W-1:0]  rd_start;
  logic [SIZE_W-1:0] rd_len;
  logic [BLK_W-1:0]  last_start;
  logic [SIZE_W-1:0] last_len;

  logic [CNT_W-1:0]  n;
  logic [SIZE_W:0]   pos_end;
  logic [SIZE_W-1:0] want;
  logic [SIZE_W:0]   run_end;
  logic              adjoins;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;
  logic [BLK_W-1:0]  wr_start;
  logic [SIZE_W-1:0] wr_len;
  logic              bump;
  logic [1:0]        res_status;

  assign n         = ext_count[req_file];
  assign stat.more = (k < n);
  assign pos_end   = {1'b0, pos} + {1'b0, rd_len};
  assign want      = req_need - pos;
  assign run_end   = {1'b0, used} + {1'b0, want};
  assign adjoins   = (n != '0) &&
                     (({2'b00, last_start} + {1'b0, last_len}) == {1'b0, used});

  // Grow decision and table update.
  always_comb begin
    wr_en      = 1'b0;
    wr_slot    = {req_file, k[EXT_W-1:0]};
    wr_start   = used[BLK_W-1:0];
    wr_len     = want;
    bump       = 1'b0;
    res_status = ST_OK;
    if (req_mode == MODE_MAP) begin
      res_status = hit ? ST_OK : ST_BEYOND;
    end else if (req_need > pos) begin
      if (run_end > {1'b0, BLOCKS_C}) begin
        res_status = ST_NOSPACE;
      end else if (adjoins) begin
        wr_en    = 1'b1;
        wr_slot  = {req_file, EXT_W'(n - 1'b1)};
        wr_start = last_start;
        wr_len   = last_len + want;
      end else if (n < MAX_EXT_C) begin
        wr_en   = 1'b1;
        wr_slot = {req_file, n[EXT_W-1:0]};
        bump    = 1'b1;
      end else begin
        res_status = ST_NOSPACE;
      end
    end
  end

  // Extent memory: one registered read port, one write port.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_start <= ext_start[{req_file, k[EXT_W-1:0]}];
      rd_len   <= ext_len[{req_file, k[EXT_W-1:0]}];
    end
    if (cmd.finish && wr_en) begin
      ext_start[wr_slot] <= wr_start;
      ext_len[wr_slot]   <= wr_len;
    end
  end

  // Extent counts and fill mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int i = 0; i < FILES; i++) begin
        ext_count[i] <= '0;
      end
    end else if (cmd.finish && wr_en) begin
      used <= run_end[SIZE_W-1:0];
      if (bump) begin
        ext_count[req_file] <= n + 1'b1;
      end
    end
  end

  // Request capture, extent walk and result register.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_mode <= mode;
      req_file <= file_id;
      req_need <= target_blocks;
      req_idx  <= block_index;
      k        <= '0;
      pos      <= '0;
      hit      <= 1'b0;
      hit_addr <= '0;
    end
    if (cmd.accum) begin
      if (!hit && ({2'b00, req_idx} < pos_end)) begin
        hit      <= 1'b1;
        hit_addr <= rd_start + (req_idx - pos[BLK_W-1:0]);
      end
      pos        <= pos_end[SIZE_W-1:0];
      last_start <= rd_start;
      last_len   <= rd_len;
      k          <= k + 1'b1;
    end
    if (cmd.finish) begin
      status        <= res_status;
      block_address <= (req_mode == MODE_MAP && hit) ? hit_addr : '0;
    end
  end

endmodule

// ===== hdl/bea_checker.sv =====
// ----------------------------------------------------------------------------
// bea_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_extent_allocator_top_macros.svh"

module bea_checker import bea_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       status,
  input logic [BLK_W-1:0] block_address
);

  // A stalled result stays valid and holds its status.
  `BEA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
  // Only the three defined result codes appear.
  `BEA_ASSERT_IMP(a_status_code, out_valid, status <= ST_BEYOND)
  // A failed map reports address zero.
  `BEA_ASSERT_IMP(a_beyond_zero, out_valid && status == ST_BEYOND, block_address == '0)
  // The block is busy in the cycle after it takes a request.
  `BEA_ASSERT_NXT(a_busy_after, in_valid && in_ready, !in_ready)

endmodule

bind bitmap_extent_allocator_top bea_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .block_address (block_address)
);
